// File: sv/srpi_pkg.sv
// ----------------------------------------------------------------------------
// srpi_pkg
// Shared constants and types for the small ring polynomial inverse core.
// ----------------------------------------------------------------------------
package srpi_pkg;

    localparam int MODULUS_DEF = 641;
    localparam int DEGREE_DEF  = 2;
    localparam int FIELD_W     = 14;
    localparam int MOD_W       = 14;
    localparam int PROD_W      = 2 * MOD_W + 2;
    localparam int STEPS       = 2 * DEGREE_DEF - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREEZE,
        ST_MULT,
        ST_EXP,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic               busy;
    } mul_ctrl_t;

endpackage

// File: sv/srpi_modmul.sv
// ----------------------------------------------------------------------------
// srpi_modmul
// Shared multi-cycle unit: centered residue of a*b - c*d mod MODULUS.
// Pipeline: products plus offset, reciprocal multiply for the
// quotient, quotient back-subtract, then one compare and subtract.
// ----------------------------------------------------------------------------
module srpi_modmul
    import srpi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_ctrl_t                ctrl,
    input  logic signed [MOD_W-1:0]  a,
    input  logic signed [MOD_W-1:0]  b,
    input  logic signed [MOD_W-1:0]  c,
    input  logic signed [MOD_W-1:0]  d,
    output logic                     done,
    output logic signed [MOD_W-1:0]  result
);

    localparam int     HALF  = (MODULUS - 1) >> 1;
    localparam int     Y_W   = 32;
    localparam int     QP_W  = 2 * Y_W;
    localparam int     R_W   = 16;
    localparam longint BIAS  = longint'(MODULUS) * ((longint'(1) << 30) / longint'(MODULUS));
    localparam longint RECIP = (longint'(1) << Y_W) / longint'(MODULUS);
    localparam logic [Y_W-1:0] OFFSET  = Y_W'(BIAS + longint'(HALF));
    localparam logic [Y_W-1:0] RECIP_K = Y_W'(RECIP);
    localparam logic [Y_W-1:0] MOD_Y   = Y_W'(MODULUS);
    localparam logic [R_W-1:0] MOD_R   = R_W'(MODULUS);
    localparam logic [R_W-1:0] HALF_R  = R_W'(HALF);

    logic signed [PROD_W-1:0] ab, cd, diff;
    logic [Y_W-1:0]           y_reg, y_next;
    logic [QP_W-1:0]          qprod;
    logic [Y_W-1:0]           q_reg, q_next;
    logic [Y_W-1:0]           qm;
    logic [R_W-1:0]           r_reg, r_next;
    logic [R_W-1:0]           r_fix;
    logic [R_W-1:0]           centered;
    logic [2:0]               stage_reg;

    assign ab     = PROD_W'(a) * PROD_W'(b);
    assign cd     = PROD_W'(c) * PROD_W'(d);
    assign diff   = ab - cd;
    assign y_next = Y_W'(diff) + OFFSET;
    assign qprod  = QP_W'(y_reg) * QP_W'(RECIP_K);
    assign q_next = qprod[QP_W-1:Y_W];
    assign qm     = q_reg * MOD_Y;
    assign r_next = R_W'(y_reg - qm);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= {stage_reg[1:0], ctrl.start};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
            y_reg <= y_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign r_fix    = (r_reg >= MOD_R) ? r_reg - MOD_R : r_reg;
    assign centered = r_fix - HALF_R;
    assign done     = stage_reg[2] && ctrl.busy;
    assign result   = centered[MOD_W-1:0];

endmodule

// File: sv/srpi_seq.sv
// ----------------------------------------------------------------------------
// srpi_seq
// Sequencer: freezes inputs, runs the divsteps, the Fermat inversion and the
// final scaling, all through the shared modular multiply unit.
// ----------------------------------------------------------------------------
module srpi_seq
    import srpi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [MOD_W-1:0]  coef_low,
    input  logic signed [MOD_W-1:0]  coef_high,
    input  logic signed [MOD_W-1:0]  root_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [MOD_W-1:0]  inv_low,
    output logic signed [MOD_W-1:0]  inv_high,
    output logic                     not_invertible
);

    localparam int EXP   = MODULUS - 2;
    localparam int EXP_W = $clog2(MODULUS + 1);
    localparam int OP_W  = 4;

    typedef logic signed [MOD_W-1:0] coef_t;

    state_t state_reg, state_next;
    coef_t phi_reg [3], ff_reg [3], vv_reg [3], ss_reg [3];
    coef_t phi_next [3], ff_next [3], vv_next [3], ss_next [3];
    coef_t nf_reg [3], nf_next [3];
    coef_t acc_reg, acc_next, base_reg, base_next, scale_reg, scale_next;
    coef_t ol_reg, ol_next, oh_reg, oh_next;
    logic signed [2:0] delta_reg, delta_next;
    logic [1:0] step_reg, step_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic ni_reg, ni_next;
    logic pend_reg, pend_next;

    mul_ctrl_t ctrl;
    coef_t ma, mb, mc, md, mres;
    logic mdone;

    srpi_modmul #(.MODULUS(MODULUS)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
        .a(ma), .b(mb), .c(mc), .d(md),
        .done(mdone), .result(mres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            phi_reg[i] <= phi_next[i];
            ff_reg[i]  <= ff_next[i];
            vv_reg[i]  <= vv_next[i];
            ss_reg[i]  <= ss_next[i];
            nf_reg[i]  <= nf_next[i];
        end
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        scale_reg <= scale_next;
        ol_reg    <= ol_next;
        oh_reg    <= oh_next;
        delta_reg <= delta_next;
        step_reg  <= step_next;
        op_reg    <= op_next;
        e_reg     <= e_next;
        ni_reg    <= ni_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        phi_next = phi_reg; ff_next = ff_reg; vv_next = vv_reg; ss_next = ss_reg;
        nf_next = nf_reg;
        acc_next = acc_reg; base_next = base_reg; scale_next = scale_reg;
        ol_next = ol_reg; oh_next = oh_reg; delta_next = delta_reg;
        step_next = step_reg; op_next = op_reg; e_next = e_reg; ni_next = ni_reg;
        ctrl.start = 1'b0;
        ctrl.busy  = pend_reg;
        ma = '0; mb = '0; mc = '0; md = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);

        unique case (op_reg)
            4'd0: begin ma = phi_reg[2]; mb = coef_t'(1); end
            4'd1: begin ma = ff_reg[0];  mb = coef_t'(1); end
            4'd2: begin ma = ff_reg[1];  mb = coef_t'(1); end
            4'd3: begin ma = phi_reg[0]; mb = ff_reg[1]; mc = ff_reg[0]; md = phi_reg[1]; end
            4'd4: begin ma = phi_reg[0]; mb = ff_reg[2]; mc = ff_reg[0]; md = phi_reg[2]; end
            4'd5: begin ma = phi_reg[0]; mb = ss_reg[0]; mc = ff_reg[0]; md = vv_reg[0]; end
            4'd6: begin ma = phi_reg[0]; mb = ss_reg[1]; mc = ff_reg[0]; md = vv_reg[1]; end
            4'd7: begin ma = phi_reg[0]; mb = ss_reg[2]; mc = ff_reg[0]; md = vv_reg[2]; end
            4'd8: begin ma = acc_reg;    mb = base_reg; end
            4'd9: begin ma = base_reg;   mb = base_reg; end
            4'd10: begin ma = scale_reg; mb = vv_reg[1]; end
            4'd11: begin ma = scale_reg; mb = vv_reg[0]; end
            default: ;
        endcase

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    nf_next[0] = root_value;
                    nf_next[1] = coef_high;
                    nf_next[2] = coef_low;
                    phi_next[2] = root_value;
                    ff_next[0] = coef_high;
                    ff_next[1] = coef_low;
                    op_next = '0;
                    state_next = ST_FREEZE;
                    ctrl.start = 1'b0;
                    pend_next = 1'b0;
                end
            end
            ST_FREEZE:
            begin
                if (!pend_reg)
                begin
                    ctrl.start = 1'b1; ctrl.busy = 1'b1; pend_next = 1'b1;
                end
                else if (mdone)
                begin
                    if (op_reg == 4'd0) phi_next[2] = mres;
                    else if (op_reg == 4'd1) ff_next[0] = mres;
                    else ff_next[1] = mres;
                    if (op_reg == 4'd2)
                    begin
                        phi_next[0] = coef_t'(1); phi_next[1] = '0;
                        ff_next[2] = '0;
                        for (int i = 0; i < 3; i++) vv_next[i] = '0;
                        ss_next[0] = coef_t'(1); ss_next[1] = '0; ss_next[2] = '0;
                        delta_next = 3'sd1;
                        step_next = '0;
                        op_next = 4'd15;
                        state_next = ST_MULT;
                    end
                    else
                        op_next = op_reg + 1'b1;
                end
                else
                    pend_next = 1'b1;
            end
            ST_MULT:
            begin
                if (op_reg == 4'd15)
                begin
                    vv_next[2] = vv_reg[1]; vv_next[1] = vv_reg[0]; vv_next[0] = '0;
                    if (delta_reg > 0 && ff_reg[0] != '0)
                    begin
                        phi_next = ff_reg; ff_next = phi_reg;
                        vv_next[0] = ss_reg[0]; vv_next[1] = ss_reg[1];
                        vv_next[2] = ss_reg[2];
                        ss_next[0] = '0; ss_next[1] = vv_reg[0]; ss_next[2] = vv_reg[1];
                        delta_next = -delta_reg + 3'sd1;
                    end
                    else
                        delta_next = delta_reg + 3'sd1;
                    op_next = 4'd3;
                end
                else if (!pend_reg)
                begin
                    ctrl.start = 1'b1; ctrl.busy = 1'b1; pend_next = 1'b1;
                end
                else if (mdone)
                begin
                    unique case (op_reg)
                        4'd3: nf_next[0] = mres;
                        4'd4: nf_next[1] = mres;
                        4'd5: nf_next[2] = mres;
                        4'd6: ss_next[1] = mres;
                        default: ss_next[2] = mres;
                    endcase
                    if (op_reg == 4'd7)
                    begin
                        ff_next[0] = nf_reg[0]; ff_next[1] = nf_reg[1]; ff_next[2] = '0;
                        ss_next[0] = nf_reg[2];
                        if (step_reg == 2'(STEPS - 1))
                        begin
                            acc_next = coef_t'(1);
                            base_next = phi_reg[0];
                            e_next = EXP_W'(EXP);
                            op_next = 4'd8;
                            state_next = ST_EXP;
                        end
                        else
                        begin
                            step_next = step_reg + 1'b1;
                            op_next = 4'd15;
                        end
                    end
                    else
                        op_next = op_reg + 1'b1;
                end
                else
                    pend_next = 1'b1;
            end
            ST_EXP:
            begin
                if (e_reg == '0)
                begin
                    scale_next = acc_reg;
                    op_next = 4'd10;
                    state_next = ST_SCALE;
                end
                else if (op_reg == 4'd8 && !e_reg[0])
                    op_next = 4'd9;
                else if (!pend_reg)
                begin
                    ctrl.start = 1'b1; ctrl.busy = 1'b1; pend_next = 1'b1;
                end
                else if (mdone)
                begin
                    if (op_reg == 4'd8)
                    begin
                        acc_next = mres;
                        op_next = 4'd9;
                    end
                    else
                    begin
                        base_next = mres;
                        e_next = e_reg >> 1;
                        op_next = 4'd8;
                    end
                end
                else
                    pend_next = 1'b1;
            end
            ST_SCALE:
            begin
                if (!pend_reg)
                begin
                    ctrl.start = 1'b1; ctrl.busy = 1'b1; pend_next = 1'b1;
                end
                else if (mdone)
                begin
                    if (op_reg == 4'd10)
                    begin
                        ol_next = mres; op_next = 4'd11;
                    end
                    else
                    begin
                        oh_next = mres;
                        ni_next = (delta_reg != 3'sd0);
                        state_next = ST_DONE;
                    end
                end
                else
                    pend_next = 1'b1;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign inv_low        = ni_reg ? coef_t'(0) : ol_reg;
    assign inv_high       = ni_reg ? coef_t'(0) : oh_reg;
    assign not_invertible = ni_reg;

endmodule

// File: sv/small_ring_poly_inverse_core.sv
// ----------------------------------------------------------------------------
// small_ring_poly_inverse_core
// Inverse of coef_low + coef_high*x modulo x^2 + root_value over Z/MODULUS.
//
// One word enters on the input channel (in_valid/in_ready) and one word
// leaves on the output channel (out_valid/out_ready). The block handles one
// word at a time: in_ready is high only while idle. Each modular product on
// the single shared multiply unit passes through products, reciprocal
// quotient, back-subtract and final correction. At MODULUS = 641 a word
// needs 3 freezes, 3 divsteps of one swap and 5 products each, the
// exponentiation over 10 exponent bits with 8 set, and 2 scaling products.
// The result is held on the output until out_ready; a stalled receiver
// keeps the block from taking the next word. Reset returns the sequencer
// to idle with no word pending.
// ----------------------------------------------------------------------------
module small_ring_poly_inverse_core
    import srpi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [FIELD_W-1:0] coef_low,
    input  logic signed [FIELD_W-1:0] coef_high,
    input  logic signed [FIELD_W-1:0] root_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [FIELD_W-1:0] inv_low,
    output logic signed [FIELD_W-1:0] inv_high,
    output logic                      not_invertible
);

    srpi_seq #(.MODULUS(MODULUS)) u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .coef_low(coef_low), .coef_high(coef_high), .root_value(root_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .inv_low(inv_low), .inv_high(inv_high), .not_invertible(not_invertible)
    );

endmodule

// File: sv/srpi_checker.sv
// ----------------------------------------------------------------------------
// srpi_checker
// Port-level checks for the small ring polynomial inverse core.
// ----------------------------------------------------------------------------
module srpi_checker
    import srpi_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [FIELD_W-1:0] inv_low,
    input logic signed [FIELD_W-1:0] inv_high,
    input logic                      not_invertible
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accept");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inv_low) && $stable(inv_high))
        else $error("result dropped");

    a_zero_when_ni: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_invertible |-> inv_low == '0 && inv_high == '0)
        else $error("nonzero result when not invertible");

endmodule

bind small_ring_poly_inverse_core srpi_checker u_srpi_checker (.*);
